// ----- src/kfh_pkg.sv -----
`default_nettype none

package kfh_pkg;

    // input item operation codes
    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_EVAL   = 2'd3
    } mode_t;

    // curve_type register codes, anything else acts as step
    localparam logic [1:0] CURVE_LINEAR  = 2'd1;
    localparam logic [1:0] CURVE_HERMITE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // one keyframe as held in the table memory
    typedef struct packed {
        logic signed [31:0] key_time;
        logic signed [31:0] value;
        logic signed [31:0] in_slope;
        logic signed [31:0] out_slope;
    } key_t;

    localparam int KEY_BITS = $bits(key_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FIRST_RD,
        ST_FIRST_W,
        ST_LAST_W,
        ST_END_W,
        ST_SRCH,
        ST_SRCH_W,
        ST_SEG1_W,
        ST_SEG2_W,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // multiply sequence of the curve evaluation
    typedef enum logic [3:0] {
        STEP_M1,
        STEP_M2,
        STEP_TT,
        STEP_TTT,
        STEP_H1V1,
        STEP_H2V2,
        STEP_H3HI,
        STEP_H3LO,
        STEP_H4HI,
        STEP_H4LO,
        STEP_LIN
    } step_t;

endpackage

`default_nettype wire

// ----- src/kfh_ram.sv -----
`default_nettype none

module kfh_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/keyframe_scalar_hermite_track.sv -----
`default_nettype none

// channel   direction  handshake             word
// cfg       in         cfg_valid/cfg_ready   curve_type
// in        in         in_valid/in_stall     mode, key_slot, query_time, new_* key fields
// out       out        out_valid/out_stall   out_value, appended_slot, count_now, times, status
//
// one item at a time; append and overwrite write the key memory as the item is taken,
// remove runs a shift sweep through the key memory that reads and rewrites each later key
// evaluate with the hermite curve uses search reads of the single read port of the key
// memory, a 16-step divider for the segment parameter and a shared 34x34 multiplier run
// over 10 products (linear needs one)
// rst_n clears count, end times and curve_type; the key memory is not cleared
// a finished word waits in the output register while the next word is taken

module keyframe_scalar_hermite_track #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [1:0]  curve_type,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [1:0]  mode,
    input  wire logic        [5:0]  key_slot,
    input  wire logic signed [31:0] query_time,
    input  wire logic signed [31:0] new_time,
    input  wire logic signed [31:0] new_value,
    input  wire logic signed [31:0] new_in_slope,
    input  wire logic signed [31:0] new_out_slope,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_value,
    output logic        [5:0]       appended_slot,
    output logic        [6:0]       count_now,
    output logic signed [31:0]      first_time,
    output logic signed [31:0]      last_time,
    output logic        [1:0]       status
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic signed [67:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh0_0000_0000_8000_0000;
    localparam logic        [16:0] T_ONE  = 17'h10000;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > SAT_HI)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < SAT_LO)
        begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // control state
    kfh_pkg::state_t state_reg, state_next;
    kfh_pkg::step_t  step_reg, step_next;
    logic            phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      curve_reg;
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      div_cnt_reg, div_cnt_next;

    // working registers
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] last_reg, last_next;
    logic signed [31:0] q_reg, q_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      mid_reg, mid_next;
    kfh_pkg::key_t      key1_reg, key1_next;
    kfh_pkg::key_t      key2_reg, key2_next;
    logic signed [32:0] dt_reg, dt_next;
    logic [32:0]        rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    logic [16:0]        tpar_reg, tpar_next;
    logic [16:0]        tt_reg, tt_next;
    logic [16:0]        ttt_reg, ttt_next;
    logic signed [49:0] m1_reg, m1_next;
    logic signed [49:0] m2_reg, m2_next;
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] prod_reg;
    logic signed [31:0] res_value_reg, res_value_next;
    logic [5:0]         res_slot_reg, res_slot_next;
    logic [1:0]         res_status_reg, res_status_next;

    // output word register
    logic signed [31:0] out_value_reg, out_value_next;
    logic [5:0]         out_slot_reg, out_slot_next;
    logic [6:0]         out_count_reg, out_count_next;
    logic signed [31:0] out_first_reg, out_first_next;
    logic signed [31:0] out_last_reg, out_last_next;
    logic [1:0]         out_status_reg, out_status_next;

    // memory port
    logic                            wr_en, rd_en;
    logic [AW-1:0]                   wr_addr, rd_addr;
    kfh_pkg::key_t                   wr_key, rd_key;
    logic [kfh_pkg::KEY_BITS-1:0]    rd_data;

    // datapath helpers
    logic               in_acc, out_fire;
    logic               slot_bad;
    logic [AW-1:0]      slot_addr, last_addr;
    logic [AW:0]        mid_sum;
    logic signed [32:0] dt_c, diff_c;
    logic [33:0]        rem2_c;
    logic signed [19:0] tp_s, tt_s, ttt_s, h1, h2, h3, h4;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] acc_sum;
    kfh_pkg::key_t      in_key;

    kfh_ram #(
        .WIDTH (kfh_pkg::KEY_BITS),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != kfh_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign in_key.key_time  = new_time;
    assign in_key.value     = new_value;
    assign in_key.in_slope  = new_in_slope;
    assign in_key.out_slope = new_out_slope;

    assign slot_bad  = 32'(key_slot) >= 32'(count_reg);
    assign slot_addr = AW'(key_slot);
    assign last_addr = AW'(count_reg - CW'(1));
    assign mid_sum   = (AW+1)'(lo_reg) + (AW+1)'(hi_reg) + (AW+1)'(1);

    // segment length and offset of the query into it
    assign dt_c   = 33'(key2_reg.key_time) - 33'(key1_reg.key_time);
    assign diff_c = 33'(q_reg) - 33'(key1_reg.key_time);
    assign rem2_c = {rem_reg, 1'b0};

    // hermite basis from t, t^2, t^3
    assign tp_s  = $signed({3'b000, tpar_reg});
    assign tt_s  = $signed({3'b000, tt_reg});
    assign ttt_s = $signed({3'b000, ttt_reg});
    assign h1    = (ttt_s <<< 1) - (tt_s + (tt_s <<< 1)) + 20'sd65536;
    assign h2    = (tt_s + (tt_s <<< 1)) - (ttt_s <<< 1);
    assign h3    = ttt_s - (tt_s <<< 1) + tp_s;
    assign h4    = ttt_s - tt_s;

    // shared multiplier operands
    always_comb
    begin
        case (step_reg)
            kfh_pkg::STEP_M1:
            begin
                mul_a = 34'(key1_reg.out_slope);
                mul_b = 34'(dt_reg);
            end
            kfh_pkg::STEP_M2:
            begin
                mul_a = 34'(key2_reg.in_slope);
                mul_b = 34'(dt_reg);
            end
            kfh_pkg::STEP_TT:
            begin
                mul_a = 34'(tp_s);
                mul_b = 34'(tp_s);
            end
            kfh_pkg::STEP_TTT:
            begin
                mul_a = 34'(tt_s);
                mul_b = 34'(tp_s);
            end
            kfh_pkg::STEP_H1V1:
            begin
                mul_a = 34'(h1);
                mul_b = 34'(key1_reg.value);
            end
            kfh_pkg::STEP_H2V2:
            begin
                mul_a = 34'(h2);
                mul_b = 34'(key2_reg.value);
            end
            kfh_pkg::STEP_H3HI:
            begin
                mul_a = 34'(h3);
                mul_b = m1_reg[49:16];
            end
            kfh_pkg::STEP_H3LO:
            begin
                mul_a = 34'(h3);
                mul_b = $signed({18'd0, m1_reg[15:0]});
            end
            kfh_pkg::STEP_H4HI:
            begin
                mul_a = 34'(h4);
                mul_b = m2_reg[49:16];
            end
            kfh_pkg::STEP_H4LO:
            begin
                mul_a = 34'(h4);
                mul_b = $signed({18'd0, m2_reg[15:0]});
            end
            kfh_pkg::STEP_LIN:
            begin
                mul_a = 34'(key2_reg.value) - 34'(key1_reg.value);
                mul_b = 34'(tp_s);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate with the high half of a split product shifted up
    always_comb
    begin
        if (step_reg == kfh_pkg::STEP_H3HI || step_reg == kfh_pkg::STEP_H4HI)
        begin
            acc_sum = acc_reg + (prod_reg <<< 16);
        end
        else
        begin
            acc_sum = acc_reg + prod_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        div_cnt_next    = div_cnt_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        q_next          = q_reg;
        ptr_next        = ptr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key1_next       = key1_reg;
        key2_next       = key2_reg;
        dt_next         = dt_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        tpar_next       = tpar_reg;
        tt_next         = tt_reg;
        ttt_next        = ttt_reg;
        m1_next         = m1_reg;
        m2_next         = m2_reg;
        acc_next        = acc_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_key          = in_key;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            kfh_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    q_next          = query_time;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    res_status_next = kfh_pkg::STATUS_OK;
                    state_next      = kfh_pkg::ST_DONE;
                    case (kfh_pkg::mode_t'(mode))
                        kfh_pkg::MODE_APPEND:
                        begin
                            if (count_reg >= CW'(MAX_KEYS))
                            begin
                                res_status_next = kfh_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = AW'(count_reg);
                                res_slot_next = 6'(count_reg);
                                count_next    = count_reg + CW'(1);
                                last_next     = new_time;
                                if (count_reg == '0)
                                begin
                                    first_next = new_time;
                                end
                            end
                        end
                        kfh_pkg::MODE_WRITE:
                        begin
                            if (slot_bad)
                            begin
                                res_status_next = kfh_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = slot_addr;
                                if (key_slot == '0)
                                begin
                                    first_next = new_time;
                                end
                                if (32'(key_slot) == 32'(count_reg) - 32'd1)
                                begin
                                    last_next = new_time;
                                end
                            end
                        end
                        kfh_pkg::MODE_REMOVE:
                        begin
                            if (slot_bad)
                            begin
                                res_status_next = kfh_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                ptr_next   = slot_addr;
                                if (count_reg == CW'(1))
                                begin
                                    first_next = '0;
                                    last_next  = '0;
                                end
                                else
                                begin
                                    state_next = kfh_pkg::ST_SHIFT_RD;
                                end
                            end
                        end
                        kfh_pkg::MODE_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next = '0;
                            end
                            else if (count_reg == CW'(1) || query_time <= first_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = kfh_pkg::ST_END_W;
                            end
                            else if (query_time >= last_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = last_addr;
                                state_next = kfh_pkg::ST_END_W;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = last_addr;
                                state_next = kfh_pkg::ST_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = kfh_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // move later keys down one place, count already lowered
            kfh_pkg::ST_SHIFT_RD:
            begin
                if (CW'(ptr_reg) < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg + AW'(1);
                    state_next = kfh_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    state_next = kfh_pkg::ST_FIRST_RD;
                end
            end
            kfh_pkg::ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_key     = rd_key;
                ptr_next   = ptr_reg + AW'(1);
                state_next = kfh_pkg::ST_SHIFT_RD;
            end

            // refresh end times after a remove
            kfh_pkg::ST_FIRST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = kfh_pkg::ST_FIRST_W;
            end
            kfh_pkg::ST_FIRST_W:
            begin
                first_next = rd_key.key_time;
                rd_en      = 1'b1;
                rd_addr    = last_addr;
                state_next = kfh_pkg::ST_LAST_W;
            end
            kfh_pkg::ST_LAST_W:
            begin
                last_next  = rd_key.key_time;
                state_next = kfh_pkg::ST_DONE;
            end

            kfh_pkg::ST_END_W:
            begin
                res_value_next = rd_key.value;
                state_next     = kfh_pkg::ST_DONE;
            end

            // binary search for the last key at or before the query
            kfh_pkg::ST_SRCH:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[AW:1];
                    rd_addr    = mid_sum[AW:1];
                    state_next = kfh_pkg::ST_SRCH_W;
                end
                else
                begin
                    rd_addr    = lo_reg;
                    state_next = kfh_pkg::ST_SEG1_W;
                end
            end
            kfh_pkg::ST_SRCH_W:
            begin
                if (rd_key.key_time <= q_reg)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - AW'(1);
                end
                state_next = kfh_pkg::ST_SRCH;
            end
            kfh_pkg::ST_SEG1_W:
            begin
                key1_next  = rd_key;
                rd_en      = 1'b1;
                rd_addr    = lo_reg + AW'(1);
                state_next = kfh_pkg::ST_SEG2_W;
            end
            kfh_pkg::ST_SEG2_W:
            begin
                key2_next  = rd_key;
                state_next = kfh_pkg::ST_PREP;
            end

            // pick the curve and clamp the parameter
            kfh_pkg::ST_PREP:
            begin
                dt_next    = dt_c;
                phase_next = 1'b0;
                step_next  = (curve_reg == kfh_pkg::CURVE_LINEAR) ?
                             kfh_pkg::STEP_LIN : kfh_pkg::STEP_M1;
                if ((curve_reg != kfh_pkg::CURVE_LINEAR &&
                     curve_reg != kfh_pkg::CURVE_HERMITE) || dt_c <= 33'sd0)
                begin
                    res_value_next = key1_reg.value;
                    state_next     = kfh_pkg::ST_DONE;
                end
                else if (diff_c <= 33'sd0)
                begin
                    tpar_next  = '0;
                    state_next = kfh_pkg::ST_MUL;
                end
                else if (diff_c >= dt_c)
                begin
                    tpar_next  = T_ONE;
                    state_next = kfh_pkg::ST_MUL;
                end
                else
                begin
                    rem_next     = unsigned'(diff_c);
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = kfh_pkg::ST_DIV;
                end
            end

            // restoring division, one quotient bit a cycle
            kfh_pkg::ST_DIV:
            begin
                if (rem2_c >= {1'b0, dt_reg})
                begin
                    rem_next = 33'(rem2_c - {1'b0, dt_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2_c[32:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    tpar_next  = {1'b0, quo_next};
                    state_next = kfh_pkg::ST_MUL;
                end
            end

            // phase 0 loads the product register, phase 1 consumes it
            kfh_pkg::ST_MUL:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    case (step_reg)
                        kfh_pkg::STEP_M1:
                        begin
                            m1_next   = prod_reg[65:16];
                            step_next = kfh_pkg::STEP_M2;
                        end
                        kfh_pkg::STEP_M2:
                        begin
                            m2_next   = prod_reg[65:16];
                            step_next = kfh_pkg::STEP_TT;
                        end
                        kfh_pkg::STEP_TT:
                        begin
                            tt_next   = prod_reg[32:16];
                            step_next = kfh_pkg::STEP_TTT;
                        end
                        kfh_pkg::STEP_TTT:
                        begin
                            ttt_next  = prod_reg[32:16];
                            step_next = kfh_pkg::STEP_H1V1;
                        end
                        kfh_pkg::STEP_H1V1:
                        begin
                            acc_next  = prod_reg;
                            step_next = kfh_pkg::STEP_H2V2;
                        end
                        kfh_pkg::STEP_H2V2:
                        begin
                            acc_next  = acc_sum;
                            step_next = kfh_pkg::STEP_H3HI;
                        end
                        kfh_pkg::STEP_H3HI:
                        begin
                            acc_next  = acc_sum;
                            step_next = kfh_pkg::STEP_H3LO;
                        end
                        kfh_pkg::STEP_H3LO:
                        begin
                            acc_next  = acc_sum;
                            step_next = kfh_pkg::STEP_H4HI;
                        end
                        kfh_pkg::STEP_H4HI:
                        begin
                            acc_next  = acc_sum;
                            step_next = kfh_pkg::STEP_H4LO;
                        end
                        kfh_pkg::STEP_H4LO:
                        begin
                            res_value_next = sat32(acc_sum >>> 16);
                            state_next     = kfh_pkg::ST_DONE;
                        end
                        kfh_pkg::STEP_LIN:
                        begin
                            res_value_next = sat32(68'(key1_reg.value) + (prod_reg >>> 16));
                            state_next     = kfh_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = kfh_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // hand the word to the output register once it is free
            kfh_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = 7'(count_reg);
                    out_first_next  = first_reg;
                    out_last_next   = last_reg;
                    out_status_next = res_status_reg;
                    state_next      = kfh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kfh_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfh_pkg::ST_IDLE;
            step_reg      <= kfh_pkg::STEP_M1;
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            div_cnt_reg   <= '0;
            curve_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            div_cnt_reg   <= div_cnt_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                curve_reg <= curve_type;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        ptr_reg        <= ptr_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key1_reg       <= key1_next;
        key2_reg       <= key2_next;
        dt_reg         <= dt_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        tpar_reg       <= tpar_next;
        tt_reg         <= tt_next;
        ttt_reg        <= ttt_next;
        m1_reg         <= m1_next;
        m2_reg         <= m2_next;
        acc_reg        <= acc_next;
        prod_reg       <= mul_a * mul_b;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign appended_slot = out_slot_reg;
    assign count_now     = out_count_reg;
    assign first_time    = out_first_reg;
    assign last_time     = out_last_reg;
    assign status        = out_status_reg;

    // never read and write the same key in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("key memory read and write collide");

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count beyond table size");

    // the count only moves on a word taken at idle
    a_count_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == kfh_pkg::ST_IDLE && in_valid))
        else $error("key count changed outside an accepted word");

    // the multiply sequence only runs for linear or hermite curves
    a_mul_curve: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kfh_pkg::ST_MUL |->
        (curve_reg == kfh_pkg::CURVE_LINEAR || curve_reg == kfh_pkg::CURVE_HERMITE))
        else $error("multiply sequence with a step curve");

    // search bounds stay ordered
    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kfh_pkg::ST_SRCH_W |-> (mid_reg > lo_reg && mid_reg <= hi_reg))
        else $error("search midpoint outside bounds");

endmodule

`default_nettype wire

// ----- tb/keyframe_scalar_hermite_track_test.sv -----
`default_nettype none

module keyframe_scalar_hermite_track_test;

    localparam int NUM_KEYS   = 64;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 400;

    // one result word as the block reports it
    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         slot;
        logic [6:0]         count;
        logic signed [31:0] t_first;
        logic signed [31:0] t_last;
        logic [1:0]         stat;
    } track_word_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] curve_type;
    logic in_valid;
    logic in_stall;
    logic [1:0] mode;
    logic [5:0] key_slot;
    logic signed [31:0] query_time;
    logic signed [31:0] new_time;
    logic signed [31:0] new_value;
    logic signed [31:0] new_in_slope;
    logic signed [31:0] new_out_slope;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] out_value;
    logic [5:0] appended_slot;
    logic [6:0] count_now;
    logic signed [31:0] first_time;
    logic signed [31:0] last_time;
    logic [1:0] status;

    keyframe_scalar_hermite_track #(.MAX_KEYS(NUM_KEYS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .curve_type(curve_type),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .key_slot(key_slot),
        .query_time(query_time), .new_time(new_time), .new_value(new_value),
        .new_in_slope(new_in_slope), .new_out_slope(new_out_slope),
        .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
        .appended_slot(appended_slot), .count_now(count_now),
        .first_time(first_time), .last_time(last_time), .status(status)
    );

    // shadow copy of the key table and the curve register
    kfh_pkg::key_t shadow_keys [NUM_KEYS];
    int unsigned   shadow_count;
    logic [1:0]    shadow_curve;

    track_word_t expected_words[$];
    int          mismatch_count;
    int          word_count;
    int          eval_count;
    longint      cycle_count;
    bit          quiet_out;     // no stalls from the receiver
    bit          quiet_in;      // no gaps from the sender
    int          hold_cycles;   // long receiver hold-off, counted down per cycle

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // floor shift of a signed value
    function automatic longint floor_shift(longint x);
        return x >>> 16;
    endfunction

    function automatic longint clamp_q16(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // evaluate the shadow track at query q
    function automatic longint track_value(longint q);
        int unsigned lo, hi, mid, i;
        longint v1, v2, t1, dt, num, t, tt, ttt, h1, h2, h3, h4, m1, m2, acc;
        if (shadow_count == 0)
            return 0;
        if (shadow_count == 1 || q <= shadow_keys[0].key_time)
            return shadow_keys[0].value;
        if (q >= shadow_keys[shadow_count-1].key_time)
            return shadow_keys[shadow_count-1].value;
        lo = 0;
        hi = shadow_count - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (shadow_keys[mid].key_time <= q)
                lo = mid;
            else
                hi = mid - 1;
        end
        i = lo;
        if (i >= shadow_count - 1)
            return shadow_keys[shadow_count-1].value;
        v1 = shadow_keys[i].value;
        v2 = shadow_keys[i+1].value;
        if (shadow_curve != kfh_pkg::CURVE_LINEAR && shadow_curve != kfh_pkg::CURVE_HERMITE)
            return v1;
        t1 = shadow_keys[i].key_time;
        dt = longint'(shadow_keys[i+1].key_time) - t1;
        if (dt <= 0)
            return v1;
        num = (q - t1) * 65536;
        if (num <= 0)
            t = 0;
        else if (num >= dt * 65536)
            t = 65536;
        else
            t = num / dt;
        if (shadow_curve == kfh_pkg::CURVE_LINEAR)
            return clamp_q16(v1 + floor_shift((v2 - v1) * t));
        tt  = (t * t) >>> 16;
        ttt = (tt * t) >>> 16;
        h1 = 2 * ttt - 3 * tt + 65536;
        h2 = 3 * tt - 2 * ttt;
        h3 = ttt - 2 * tt + t;
        h4 = ttt - tt;
        m1 = floor_shift(longint'(shadow_keys[i].out_slope) * dt);
        m2 = floor_shift(longint'(shadow_keys[i+1].in_slope) * dt);
        acc = h1 * v1 + h2 * v2 + h3 * m1 + h4 * m2;
        return clamp_q16(floor_shift(acc));
    endfunction

    // apply one word to the shadow table and return what the block should report
    function automatic track_word_t apply_word(kfh_pkg::mode_t m, logic [5:0] s,
                                               logic signed [31:0] q, kfh_pkg::key_t k);
        track_word_t w;
        w = '0;
        case (m)
            kfh_pkg::MODE_APPEND:
                if (shadow_count >= NUM_KEYS)
                    w.stat = kfh_pkg::STATUS_FULL;
                else
                begin
                    shadow_keys[shadow_count] = k;
                    w.slot = shadow_count[5:0];
                    shadow_count++;
                end
            kfh_pkg::MODE_WRITE:
                if (s >= shadow_count)
                    w.stat = kfh_pkg::STATUS_RANGE;
                else
                    shadow_keys[s] = k;
            kfh_pkg::MODE_REMOVE:
                if (s >= shadow_count)
                    w.stat = kfh_pkg::STATUS_RANGE;
                else
                begin
                    for (int j = s; j + 1 < shadow_count; j++)
                        shadow_keys[j] = shadow_keys[j+1];
                    shadow_count--;
                end
            default:
                w.value = 32'(track_value(longint'(q)));
        endcase
        w.count = shadow_count[6:0];
        if (shadow_count != 0)
        begin
            w.t_first = shadow_keys[0].key_time;
            w.t_last  = shadow_keys[shadow_count-1].key_time;
        end
        return w;
    endfunction

    // random gap with valid low, or none
    task automatic sender_gap();
        if (!quiet_in && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // drive one word and wait for it to be taken; valid stays up for the next word
    task automatic send_word(kfh_pkg::mode_t m, logic [5:0] s, logic signed [31:0] q,
                             kfh_pkg::key_t k);
        sender_gap();
        in_valid      <= 1'b1;
        mode          <= m;
        key_slot      <= s;
        query_time    <= q;
        new_time      <= k.key_time;
        new_value     <= k.value;
        new_in_slope  <= k.in_slope;
        new_out_slope <= k.out_slope;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_words.insert(expected_words.size(), apply_word(m, s, q, k));
        if (m == kfh_pkg::MODE_EVAL)
            eval_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // curve register is only written while the block is idle
    task automatic write_curve(logic [1:0] c);
        wait_idle();
        cfg_valid  <= 1'b1;
        curve_type <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_curve = c;
    endtask

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'($urandom);
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    function automatic kfh_pkg::key_t rand_key(logic signed [31:0] t);
        kfh_pkg::key_t k;
        k.key_time = t;
        k.value    = rand_q16();
        k.in_slope = rand_q16();
        k.out_slope = rand_q16();
        return k;
    endfunction

    // evaluate somewhere near the current span of the track
    function automatic logic signed [31:0] near_query();
        longint lo, hi;
        if (shadow_count == 0 || $urandom_range(0, 7) == 0)
            return 32'($urandom);
        lo = shadow_keys[0].key_time;
        hi = shadow_keys[shadow_count-1].key_time;
        if (hi <= lo)
            return 32'(lo + $signed($urandom_range(0, 8)) - 4);
        return 32'(lo - 16 + longint'($urandom) % (hi - lo + 32));
    endfunction

    // build a sorted track of n keys with random spacing
    task automatic build_track(int n, logic signed [31:0] t0);
        longint t;
        t = t0;
        for (int j = 0; j < n; j++)
        begin
            send_word(kfh_pkg::MODE_APPEND, 6'($urandom), 32'($urandom), rand_key(32'(t)));
            t += $urandom_range(1, 32'h0003_0000);
        end
    endtask

    task automatic clear_track();
        while (shadow_count != 0)
            send_word(kfh_pkg::MODE_REMOVE, 6'($urandom_range(0, shadow_count - 1)), '0,
                      rand_key('0));
    endtask

    // directed: empty table, range errors, extremes and all three curve types
    task automatic test_directed();
        kfh_pkg::key_t k;
        send_word(kfh_pkg::MODE_EVAL, '0, 32'sh7FFFFFFF, rand_key('0));
        send_word(kfh_pkg::MODE_WRITE, 6'd0, '0, rand_key('0));
        send_word(kfh_pkg::MODE_REMOVE, 6'd63, '0, rand_key('0));
        k = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        send_word(kfh_pkg::MODE_APPEND, '0, '0, k);
        send_word(kfh_pkg::MODE_EVAL, '0, 32'sh80000000, k);       // single key
        k = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_word(kfh_pkg::MODE_APPEND, '0, '0, k);
        for (int c = 0; c < 4; c++)
        begin
            write_curve(2'(c));
            send_word(kfh_pkg::MODE_EVAL, '0, 32'sh0000_0000, k);
            send_word(kfh_pkg::MODE_EVAL, '0, 32'sh7FFFFFFE, k);
        end
        // equal times give a non-positive segment
        k = '{32'sh7FFFFFFF, 32'sh0001_0000, '0, '0};
        send_word(kfh_pkg::MODE_WRITE, 6'd0, '0, k);
        send_word(kfh_pkg::MODE_APPEND, '0, '0, k);
        send_word(kfh_pkg::MODE_EVAL, '0, 32'sh7FFFFFF0, k);
        // unsorted keys still give a defined answer
        send_word(kfh_pkg::MODE_WRITE, 6'd1, '0, '{32'sh0, 32'sh5, 32'sh7, 32'sh9});
        send_word(kfh_pkg::MODE_EVAL, '0, 32'sh1000, k);
        send_word(kfh_pkg::MODE_REMOVE, 6'd2, '0, k);
        send_word(kfh_pkg::MODE_REMOVE, 6'd0, '0, k);
        send_word(kfh_pkg::MODE_REMOVE, 6'd0, '0, k);
    endtask

    // fill the table to its limit and push past it
    task automatic test_full_table();
        write_curve(kfh_pkg::CURVE_HERMITE);
        build_track(NUM_KEYS, 32'sh8000_0000);
        send_word(kfh_pkg::MODE_APPEND, '0, '0, rand_key('0));
        send_word(kfh_pkg::MODE_WRITE, 6'd63, '0, rand_key(32'h7FFF_0000));
        for (int j = 0; j < 8; j++)
            send_word(kfh_pkg::MODE_EVAL, '0, near_query(), rand_key('0));
        send_word(kfh_pkg::MODE_REMOVE, 6'd0, '0, rand_key('0));
        clear_track();
    endtask

    // random tracks under each curve setting, mostly well-formed sequences
    task automatic test_random_tracks(int total);
        int done;
        done = 0;
        while (done < total)
        begin
            write_curve(2'($urandom_range(0, 3)));
            build_track($urandom_range(2, 12), 32'($urandom_range(0, 32'h0040_0000)) -
                        32'sh0020_0000);
            done += shadow_count;
            repeat ($urandom_range(15, 30))
            begin
                case ($urandom_range(0, 9))
                    0: send_word(kfh_pkg::MODE_WRITE, 6'($urandom_range(0, shadow_count)), '0,
                                 rand_key(near_query()));
                    1: send_word(kfh_pkg::MODE_REMOVE, 6'($urandom), '0, rand_key('0));
                    2: send_word(kfh_pkg::MODE_APPEND, 6'($urandom), 32'($urandom),
                                 rand_key(32'($urandom)));
                    default: send_word(kfh_pkg::MODE_EVAL, 6'($urandom), near_query(),
                                       rand_key(32'($urandom)));
                endcase
                done++;
            end
            clear_track();
        end
    endtask

    // receiver holds off long enough that the block backs up
    task automatic test_back_pressure();
        write_curve(kfh_pkg::CURVE_LINEAR);
        hold_cycles = 300;
        build_track(6, '0);
        repeat (6)
            send_word(kfh_pkg::MODE_EVAL, '0, near_query(), rand_key('0));
        clear_track();
    endtask

    // receiver: random stall bursts, plus the long hold-off
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else if (!quiet_out && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5) - 1) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // checker: compare each taken word with the oldest expectation
    initial
    begin
        track_word_t want;
        track_word_t got;
        mismatch_count = 0;
        word_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{out_value, appended_slot, count_now, first_time, last_time, status};
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word %h", got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    word_count++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("word %0d (expected/actual): value %h/%h slot %0d/%0d",
                                     word_count, want.value, got.value, want.slot, got.slot);
                            $display("  count %0d/%0d first %h/%h last %h/%h status %0d/%0d",
                                     want.count, got.count, want.t_first, got.t_first,
                                     want.t_last, got.t_last, want.stat, got.stat);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        curve_type = '0;
        in_valid = 1'b0;
        mode = kfh_pkg::MODE_APPEND;
        key_slot = '0;
        query_time = '0;
        new_time = '0;
        new_value = '0;
        new_in_slope = '0;
        new_out_slope = '0;
        quiet_out = 1'b0;
        quiet_in = 1'b0;
        hold_cycles = 0;
        eval_count = 0;
        shadow_count = 0;
        shadow_curve = '0;
        foreach (shadow_keys[j])
            shadow_keys[j] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_back_pressure();
        test_random_tracks(240);
        // last part runs with no idling on either side
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        test_random_tracks(80);
        wait_idle();

        $display("checked %0d result words, %0d of them evaluations, over all curve settings",
                 word_count, eval_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/kfh_pkg.sv
src/kfh_ram.sv
src/keyframe_scalar_hermite_track.sv
tb/keyframe_scalar_hermite_track_test.sv
